FILE: sv/v3alu_pkg.sv
// package for the three-component q16.16 vector unit
// holds mode codes, register index, stage depths, the carried-result type and the clamp helper
// no dependencies
package v3alu_pkg;

  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_MUL   = 4'd2;
  localparam logic [3:0] MODE_SCALE = 4'd3;
  localparam logic [3:0] MODE_DOT   = 4'd4;
  localparam logic [3:0] MODE_CROSS = 4'd5;
  localparam logic [3:0] MODE_LENSQ = 4'd6;
  localparam logic [3:0] MODE_LEN   = 4'd7;
  localparam logic [3:0] MODE_NORM  = 4'd8;
  localparam logic [3:0] MODE_DIST  = 4'd9;
  localparam logic [3:0] MODE_LERP  = 4'd10;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_EPS = 1'b0;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 17;
  localparam int CAR_LAST = SQ_STEPS + 1 + DV_STEPS;

  localparam logic [16:0] EPS_RESET = 17'd1;
  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX   = 32'h8000_0000;

  // result fields already final for the short modes, plus normalize operands
  typedef struct packed {
    logic [3:0]       mode;
    logic             big;
    logic             sat;
    logic [31:0]      ox;
    logic [31:0]      oy;
    logic [31:0]      oz;
    logic [31:0]      os;
    logic [2:0]       sgn;
    logic [2:0][31:0] mag;
  } car_t;

  // {flag, value}: clamp a wide signed value to 32 bits
  function automatic logic [32:0] clamp52(input logic signed [51:0] v);
    logic hi_ok;
    hi_ok = (v[51:31] == {21{1'b0}}) || (v[51:31] == {21{1'b1}});
    if (hi_ok) begin
      clamp52 = {1'b0, v[31:0]};
    end else begin
      clamp52 = {1'b1, (v[51] ? NEG_MAX : POS_MAX)};
    end
  endfunction

endpackage

FILE: sv/vec3_fixed_point_alu.sv
// three-component q16.16 vector unit, top level and whole datapath
// depends on v3alu_pkg
// Fully pipelined: one request is taken every cycle unless the output stalls, and every
// mode takes the same path to the output. Four stages capture the request,
// select operands, multiply and form wide sums, which are clamped on entry to the carry
// line; a 32-stage root pipeline (one result bit per stage) gives lengths, and a 17-stage
// restoring divider (one quotient bit per stage, three lanes) does normalize. A stall
// at the output freezes the whole pipe; nothing is dropped or repeated. The epsilon
// register sits at byte address 0 and must be written only while the pipe is empty.
module vec3_fixed_point_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_scalar_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_scalar,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CL = v3alu_pkg::CAR_LAST;
  localparam int SQ = v3alu_pkg::SQ_STEPS;
  localparam int DV = v3alu_pkg::DV_STEPS;

  logic        adv;
  logic [16:0] eps_r;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == v3alu_pkg::REG_EPS) ? {15'd0, eps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= v3alu_pkg::EPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == v3alu_pkg::REG_EPS)) begin
      eps_r <= pwdata[16:0];
    end
  end

  logic out_vld_r;
  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_vld_r;

  // stage 0: input capture
  logic                    v0_r;
  logic [3:0]              m0_r;
  logic signed [2:0][31:0] a0_r, b0_r;
  logic signed [31:0]      t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r    <= in_mode;
      a0_r[0] <= in_a_x;
      a0_r[1] <= in_a_y;
      a0_r[2] <= in_a_z;
      b0_r[0] <= in_b_x;
      b0_r[1] <= in_b_y;
      b0_r[2] <= in_b_z;
      t0_r    <= in_scalar_in;
    end
  end

  // stage 1: multiplier operand select
  logic signed [32:0] xs [3];
  logic signed [32:0] ys [3];
  logic signed [32:0] us [3];
  logic signed [32:0] ws [3];
  logic signed [32:0] av [3];
  logic signed [32:0] bv [3];
  logic signed [32:0] ev [3];
  logic signed [32:0] tv;
  logic               big1;

  always_comb begin
    tv   = {t0_r[31], t0_r};
    big1 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      av[i] = {a0_r[i][31], a0_r[i]};
      bv[i] = {b0_r[i][31], b0_r[i]};
      ev[i] = av[i] - bv[i];
      xs[i] = '0;
      ys[i] = '0;
      us[i] = '0;
      ws[i] = '0;
      // magnitude above 2^31
      if ((!ev[i][32] && ev[i][31] && (ev[i][30:0] != '0)) || (ev[i][32] && !ev[i][31])) begin
        big1 = big1 | (m0_r == v3alu_pkg::MODE_DIST);
      end
    end
    case (m0_r)
      v3alu_pkg::MODE_MUL, v3alu_pkg::MODE_DOT: begin
        for (int i = 0; i < 3; i++) begin
          xs[i] = av[i];
          ys[i] = bv[i];
        end
      end
      v3alu_pkg::MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          xs[i] = av[i];
          ys[i] = tv;
        end
      end
      v3alu_pkg::MODE_LENSQ, v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_NORM: begin
        for (int i = 0; i < 3; i++) begin
          xs[i] = av[i];
          ys[i] = av[i];
        end
      end
      v3alu_pkg::MODE_DIST: begin
        for (int i = 0; i < 3; i++) begin
          xs[i] = ev[i];
          ys[i] = ev[i];
        end
      end
      v3alu_pkg::MODE_LERP: begin
        for (int i = 0; i < 3; i++) begin
          xs[i] = bv[i] - av[i];
          ys[i] = tv;
        end
      end
      v3alu_pkg::MODE_CROSS: begin
        xs[0] = av[1]; ys[0] = bv[2]; us[0] = av[2]; ws[0] = bv[1];
        xs[1] = av[2]; ys[1] = bv[0]; us[1] = av[0]; ws[1] = bv[2];
        xs[2] = av[0]; ys[2] = bv[1]; us[2] = av[1]; ws[2] = bv[0];
      end
      default: begin
      end
    endcase
  end

  logic                    v1_r, big1_r;
  logic [3:0]              m1_r;
  logic signed [2:0][31:0] a1_r, b1_r;
  logic signed [32:0]      x1_r [3];
  logic signed [32:0]      y1_r [3];
  logic signed [32:0]      u1_r [3];
  logic signed [32:0]      w1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= m0_r;
      big1_r <= big1;
      a1_r   <= a0_r;
      b1_r   <= b0_r;
      for (int i = 0; i < 3; i++) begin
        x1_r[i] <= xs[i];
        y1_r[i] <= ys[i];
        u1_r[i] <= us[i];
        w1_r[i] <= ws[i];
      end
    end
  end

  // stage 2: products
  logic                    v2_r, big2_r;
  logic [3:0]              m2_r;
  logic signed [2:0][31:0] a2_r, b2_r;
  logic signed [65:0]      p2_r [3];
  logic signed [65:0]      q2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= m1_r;
      big2_r <= big1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= x1_r[i] * y1_r[i];
        q2_r[i] <= u1_r[i] * w1_r[i];
      end
    end
  end

  // stage 3: wide sums, sum of squares
  logic signed [51:0] rw [3];
  logic signed [51:0] pt [3];
  logic signed [51:0] qt [3];
  logic signed [51:0] aw [3];
  logic signed [51:0] bw [3];
  logic signed [51:0] sw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = {{2{p2_r[i][65]}}, p2_r[i][65:16]};
      qt[i] = {{2{q2_r[i][65]}}, q2_r[i][65:16]};
      aw[i] = {{20{a2_r[i][31]}}, a2_r[i]};
      bw[i] = {{20{b2_r[i][31]}}, b2_r[i]};
      rw[i] = '0;
    end
    sw = '0;
    case (m2_r)
      v3alu_pkg::MODE_ADD: begin
        for (int i = 0; i < 3; i++) rw[i] = aw[i] + bw[i];
      end
      v3alu_pkg::MODE_SUB: begin
        for (int i = 0; i < 3; i++) rw[i] = aw[i] - bw[i];
      end
      v3alu_pkg::MODE_MUL, v3alu_pkg::MODE_SCALE: begin
        for (int i = 0; i < 3; i++) rw[i] = pt[i];
      end
      v3alu_pkg::MODE_CROSS: begin
        for (int i = 0; i < 3; i++) rw[i] = pt[i] - qt[i];
      end
      v3alu_pkg::MODE_LERP: begin
        for (int i = 0; i < 3; i++) rw[i] = aw[i] + pt[i];
      end
      v3alu_pkg::MODE_DOT, v3alu_pkg::MODE_LENSQ: begin
        sw = pt[0] + pt[1] + pt[2];
      end
      default: begin
      end
    endcase
  end

  logic                    v3_r, big3_r;
  logic [3:0]              m3_r;
  logic signed [51:0]      r3_r [3];
  logic signed [51:0]      s3_r;
  logic [63:0]             ss3_r;
  logic [2:0]              sg3_r;
  logic [2:0][31:0]        mg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_r   <= m2_r;
      big3_r <= big2_r;
      s3_r   <= sw;
      ss3_r  <= p2_r[0][63:0] + p2_r[1][63:0] + p2_r[2][63:0];
      for (int i = 0; i < 3; i++) begin
        r3_r[i]  <= rw[i];
        sg3_r[i] <= a2_r[i][31];
        mg3_r[i] <= a2_r[i][31] ? (~a2_r[i] + 32'd1) : a2_r[i];
      end
    end
  end

  // carried results, clamp at entry
  v3alu_pkg::car_t car_r [0:CL];
  logic            cvld_r [0:CL];
  logic [32:0]     cx, cy, cz, cs;

  assign cx = v3alu_pkg::clamp52(r3_r[0]);
  assign cy = v3alu_pkg::clamp52(r3_r[1]);
  assign cz = v3alu_pkg::clamp52(r3_r[2]);
  assign cs = v3alu_pkg::clamp52(s3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r[0] <= 1'b0;
    end else if (adv) begin
      cvld_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      car_r[0].mode <= m3_r;
      car_r[0].big  <= big3_r;
      car_r[0].sat  <= cx[32] | cy[32] | cz[32] | cs[32];
      car_r[0].ox   <= cx[31:0];
      car_r[0].oy   <= cy[31:0];
      car_r[0].oz   <= cz[31:0];
      car_r[0].os   <= cs[31:0];
      car_r[0].sgn  <= sg3_r;
      car_r[0].mag  <= mg3_r;
    end
  end

  for (genvar j = 0; j < CL; j++) begin : g_car
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cvld_r[j+1] <= 1'b0;
      end else if (adv) begin
        cvld_r[j+1] <= cvld_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        car_r[j+1] <= car_r[j];
      end
    end
  end

  // integer square root, one root bit per stage
  logic [63:0] sq_n_r   [0:SQ];
  logic [35:0] sq_rem_r [0:SQ];
  logic [31:0] sq_q_r   [0:SQ];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n_r[0]   <= ss3_r;
      sq_rem_r[0] <= '0;
      sq_q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [35:0] cur, trial;
    logic        ge;
    assign cur   = {sq_rem_r[k][33:0], sq_n_r[k][63:62]};
    assign trial = {2'b00, sq_q_r[k], 2'b01};
    assign ge    = cur >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n_r[k+1]   <= {sq_n_r[k][61:0], 2'b00};
        sq_rem_r[k+1] <= ge ? (cur - trial) : cur;
        sq_q_r[k+1]   <= {sq_q_r[k][30:0], ge};
      end
    end
  end

  // normalize divide, one quotient bit per stage, three lanes
  logic [31:0]       dv_d_r   [0:DV];
  logic              dv_ok_r  [0:DV];
  logic [2:0][31:0]  dv_rem_r [0:DV];
  logic [2:0][16:0]  dv_nb_r  [0:DV];
  logic [2:0][16:0]  dv_q_r   [0:DV];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_d_r[0]  <= sq_q_r[SQ];
      dv_ok_r[0] <= (car_r[SQ].mode == v3alu_pkg::MODE_NORM) && (sq_q_r[SQ] != '0)
                    && (sq_q_r[SQ] >= {15'd0, eps_r});
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {1'b0, car_r[SQ].mag[i][31:1]};
        dv_nb_r[0][i]  <= {car_r[SQ].mag[i][0], 16'd0};
        dv_q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar m = 0; m < DV; m++) begin : g_dv
    logic [32:0] cur [3];
    logic [32:0] dd;
    logic [2:0]  ge;
    assign dd = {1'b0, dv_d_r[m]};
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign cur[i] = {dv_rem_r[m][i], dv_nb_r[m][i][16]};
      assign ge[i]  = cur[i] >= dd;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_d_r[m+1]  <= dv_d_r[m];
        dv_ok_r[m+1] <= dv_ok_r[m];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[m+1][i] <= ge[i] ? 32'(cur[i] - dd) : cur[i][31:0];
          dv_nb_r[m+1][i]  <= {dv_nb_r[m][i][15:0], 1'b0};
          dv_q_r[m+1][i]   <= {dv_q_r[m][i][15:0], ge[i]};
        end
      end
    end
  end

  // final select and output register
  v3alu_pkg::car_t  fc;
  logic [2:0][31:0] nq;
  logic [31:0]      fx, fy, fz, fs;
  logic             fsat, lbig;

  assign fc = car_r[CL];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = fc.sgn[i] ? (~{15'd0, dv_q_r[DV][i]} + 32'd1) : {15'd0, dv_q_r[DV][i]};
    end
    lbig = fc.big | dv_d_r[DV][31];
    fx   = fc.ox;
    fy   = fc.oy;
    fz   = fc.oz;
    fs   = fc.os;
    fsat = fc.sat;
    case (fc.mode)
      v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_DIST: begin
        fs   = lbig ? v3alu_pkg::POS_MAX : dv_d_r[DV];
        fsat = lbig;
      end
      v3alu_pkg::MODE_NORM: begin
        fx   = dv_ok_r[DV] ? nq[0] : '0;
        fy   = dv_ok_r[DV] ? nq[1] : '0;
        fz   = dv_ok_r[DV] ? nq[2] : '0;
        fsat = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= cvld_r[CL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x         <= fx;
      out_y         <= fy;
      out_z         <= fz;
      out_scalar    <= fs;
      out_saturated <= fsat;
    end
  end

endmodule

FILE: bench/vec3_fixed_point_alu_tb.sv
// testbench for vec3_fixed_point_alu: directed table, then random requests at several epsilon settings
// results are checked field by field against typed table values or an in-bench q16.16 predictor
// depends on v3alu_pkg and vec3_fixed_point_alu
module vec3_fixed_point_alu_tb;

  localparam int LATENCY   = 60;
  localparam int WDOG_MAX  = 3000;
  localparam int RAND_N    = 1800;
  localparam int PHASES    = 4;
  localparam logic [2:0] ADDR_EPS = {v3alu_pkg::REG_EPS, 2'b00};

  typedef struct {
    logic [31:0] x, y, z, s;
    logic        sat;
  } vres_t;

  typedef struct {
    logic [3:0]  mode;
    logic [31:0] ax, ay, az, bx, by, bz, t;
    bit          typed;
    vres_t       want;
  } vreq_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_saturated;
  logic [3:0] in_mode;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_scalar_in;
  logic signed [31:0] out_x, out_y, out_z, out_scalar;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  vec3_fixed_point_alu dut (.*);

  vres_t  pending_q[$];
  vreq_t  dir_tab[$];
  logic [16:0] eps_now;
  int errors, n_taken, idle_cnt;
  bit quiet, hold_done;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint fx_mul(longint p, longint q);
    return (p * q) >>> 16;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned vec_len(longint x, longint y, longint z);
    longint unsigned mx, my, mz, lim;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    mz = z < 0 ? -z : z;
    lim = 64'd1 << 31;
    if (mx > lim || my > lim || mz > lim) return lim;
    return sqrt_floor(mx * mx + my * my + mz * mz);
  endfunction

  function automatic logic [31:0] clamp_q(longint v, inout logic f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return v3alu_pkg::POS_MAX;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return v3alu_pkg::NEG_MAX;
    end
    return v[31:0];
  endfunction

  function automatic vres_t vec_op(vreq_t q);
    longint a[3], b[3], r[3], s, t;
    longint unsigned ln;
    vres_t o;
    a = '{longint'(signed'(q.ax)), longint'(signed'(q.ay)), longint'(signed'(q.az))};
    b = '{longint'(signed'(q.bx)), longint'(signed'(q.by)), longint'(signed'(q.bz))};
    t = longint'(signed'(q.t));
    r = '{0, 0, 0};
    s = 0;
    case (q.mode)
      v3alu_pkg::MODE_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      v3alu_pkg::MODE_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      v3alu_pkg::MODE_MUL:   for (int i = 0; i < 3; i++) r[i] = fx_mul(a[i], b[i]);
      v3alu_pkg::MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = fx_mul(a[i], t);
      v3alu_pkg::MODE_DOT:
        s = fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
      v3alu_pkg::MODE_CROSS: begin
        r[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        r[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
        r[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
      end
      v3alu_pkg::MODE_LENSQ:
        s = fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]);
      v3alu_pkg::MODE_LEN:   s = longint'(vec_len(a[0], a[1], a[2]));
      v3alu_pkg::MODE_NORM: begin
        ln = vec_len(a[0], a[1], a[2]);
        if (ln != 0 && ln >= eps_now)
          for (int i = 0; i < 3; i++) r[i] = (a[i] * 65536) / longint'(ln);
      end
      v3alu_pkg::MODE_DIST:
        s = longint'(vec_len(a[0] - b[0], a[1] - b[1], a[2] - b[2]));
      v3alu_pkg::MODE_LERP:
        for (int i = 0; i < 3; i++) r[i] = a[i] + fx_mul(b[i] - a[i], t);
      default: ;
    endcase
    o.sat = 0;
    o.x = clamp_q(r[0], o.sat);
    o.y = clamp_q(r[1], o.sat);
    o.z = clamp_q(r[2], o.sat);
    o.s = clamp_q(s, o.sat);
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic vreq_t mk(logic [3:0] m, logic [31:0] ax, ay, az, bx, by, bz, t);
    vreq_t q;
    q.mode = m;
    q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz;
    q.t = t;
    q.typed = 0;
    q.want = '{default: 0};
    return q;
  endfunction

  function automatic vreq_t mkt(vreq_t q, logic [31:0] x, y, z, s, logic f);
    q.typed = 1;
    q.want = '{x: x, y: y, z: z, s: s, sat: f};
    return q;
  endfunction

  function automatic logic [31:0] rand_comp();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 70) return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    if (sel < 85) return 32'($signed($urandom_range(0, 512)) - 256);
    case ($urandom_range(0, 4))
      0: return v3alu_pkg::POS_MAX;
      1: return v3alu_pkg::NEG_MAX;
      2: return 32'd0;
      3: return 32'h0001_0000;
      default: return 32'hffff_0000;
    endcase
  endfunction

  function automatic vreq_t rand_req();
    logic [3:0] m;
    m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    return mk(m, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp());
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send(vreq_t q);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= q.mode;
    in_a_x <= q.ax; in_a_y <= q.ay; in_a_z <= q.az;
    in_b_x <= q.bx; in_b_y <= q.by; in_b_z <= q.bz;
    in_scalar_in <= q.t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(q.typed ? q.want : vec_op(q));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_eps(logic [16:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_EPS; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    eps_now = v;
    pwrite <= 0; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata[16:0] !== v) report("eps readback", prdata, 32'(v));
    psel <= 0; penable <= 0;
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result x", out_x, 32'd0);
      end else begin
        vres_t w;
        w = pending_q.pop_front();
        if (out_x !== w.x) report("out_x", out_x, w.x);
        if (out_y !== w.y) report("out_y", out_y, w.y);
        if (out_z !== w.z) report("out_z", out_z, w.z);
        if (out_scalar !== w.s) report("out_scalar", out_scalar, w.s);
        if (out_saturated !== w.sat) report("saturated", 32'(out_saturated), 32'(w.sat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) n_taken++;
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WDOG_MAX) begin
      $display("watchdog: no progress");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off so the pipe backs up
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_taken >= 600) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    logic [16:0] eps_set[PHASES];
    rst_n = 0; in_valid = 0; in_mode = '0;
    in_a_x = 0; in_a_y = 0; in_a_z = 0; in_b_x = 0; in_b_y = 0; in_b_z = 0;
    in_scalar_in = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    errors = 0; n_taken = 0; idle_cnt = 0; quiet = 0; hold_done = 0;
    eps_now = v3alu_pkg::EPS_RESET;

    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_ADD, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_ADD, v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX,
                             v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX,
                             v3alu_pkg::POS_MAX, 0),
                          v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, 0, 1));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_SUB, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::NEG_MAX, v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX,
                             v3alu_pkg::POS_MAX, 0),
                          v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX, 0, 1));
    dir_tab.push_back(mk(v3alu_pkg::MODE_MUL, v3alu_pkg::POS_MAX, 32'h0001_8000, 32'hfffe_0000,
                         v3alu_pkg::POS_MAX, 32'h0002_0000, 32'h0000_8000, 0));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_MUL, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::NEG_MAX, 0),
                          v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, 0, 1));
    dir_tab.push_back(mk(v3alu_pkg::MODE_SCALE, 32'h1234_5678, 32'hfedc_ba98, 1, 0, 0, 0,
                         32'hffff_0001));
    dir_tab.push_back(mk(v3alu_pkg::MODE_DOT, v3alu_pkg::POS_MAX, v3alu_pkg::NEG_MAX,
                         32'h0003_0000, v3alu_pkg::POS_MAX, v3alu_pkg::NEG_MAX,
                         32'hfffd_0000, 0));
    dir_tab.push_back(mk(v3alu_pkg::MODE_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0));
    dir_tab.push_back(mk(v3alu_pkg::MODE_LENSQ, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                         v3alu_pkg::NEG_MAX, 0, 0, 0, 0));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_LEN, 32'h0001_0000, 0, 0, 0, 0, 0, 0),
                          0, 0, 0, 32'h0001_0000, 0));
    // root of three full-scale squares no longer fits
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_LEN, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::NEG_MAX, 0, 0, 0, 0),
                          0, 0, 0, v3alu_pkg::POS_MAX, 1));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_NORM, 32'h0003_0000, 0, 0, 0, 0, 0, 0),
                          32'h0001_0000, 0, 0, 0, 0));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_NORM, 0, 32'hffff_ffff, 0, 0, 0, 0, 0),
                          0, 32'hffff_0000, 0, 0, 0));
    dir_tab.push_back(mk(v3alu_pkg::MODE_NORM, v3alu_pkg::NEG_MAX, v3alu_pkg::POS_MAX,
                         32'h0000_1234, 0, 0, 0, 0));
    dir_tab.push_back(mk(v3alu_pkg::MODE_DIST, 32'h0004_0000, 0, 0, 0, 32'h0003_0000, 0, 0));
    // difference beyond 2^31 in one component
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_DIST, v3alu_pkg::POS_MAX, 0, 0,
                             v3alu_pkg::NEG_MAX, 0, 0, 0),
                          0, 0, 0, v3alu_pkg::POS_MAX, 1));
    dir_tab.push_back(mkt(mk(v3alu_pkg::MODE_LERP, 32'h0000_0005, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, 0, 0, 0),
                          32'h0000_0005, v3alu_pkg::NEG_MAX, v3alu_pkg::POS_MAX, 0, 0));
    dir_tab.push_back(mk(v3alu_pkg::MODE_LERP, v3alu_pkg::NEG_MAX, 0, 32'h0001_0000,
                         v3alu_pkg::POS_MAX, v3alu_pkg::POS_MAX, 0, v3alu_pkg::NEG_MAX));
    dir_tab.push_back(mkt(mk(4'd11, v3alu_pkg::POS_MAX, 1, 2, 3, 4, 5, 6), 0, 0, 0, 0, 0));
    dir_tab.push_back(mkt(mk(4'd15, v3alu_pkg::NEG_MAX, v3alu_pkg::NEG_MAX,
                             v3alu_pkg::NEG_MAX, 1, 1, 1, 1),
                          0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    eps_set[0] = 17'd0;
    eps_set[1] = 17'h10000;
    eps_set[2] = 17'($urandom_range(2, 65535));
    eps_set[3] = v3alu_pkg::EPS_RESET;
    for (int p = 0; p < PHASES; p++) begin
      write_eps(eps_set[p]);
      // zero-length vector with epsilon at zero must still give zero
      if (p == 0) send(mkt(mk(v3alu_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
      for (int k = 0; k < RAND_N / PHASES; k++) begin
        if (p == PHASES - 1 && k == RAND_N / PHASES - 150) quiet = 1;
        send(rand_req());
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
